### rtl/output_fault_qualifier_defines.svh
// Assertion macros shared by the output fault qualifier RTL.
// Each macro expects clk and arst_n in the scope where it is used.
`ifndef OUTPUT_FAULT_QUALIFIER_DEFINES_SVH
`define OUTPUT_FAULT_QUALIFIER_DEFINES_SVH

// Same-cycle implication, checked out of reset
`define OFQ_ASSERT_IMPL(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("ofq: same-cycle check failed");

// Next-cycle implication, checked out of reset
`define OFQ_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("ofq: next-cycle check failed");

`endif

### rtl/ofq_pkg.sv
// Shared types and constants for the output fault qualifier.
// No dependencies; imported by ofq_classify and output_fault_qualifier.
`default_nettype none

package ofq_pkg;

	localparam int MV_W       = 14;
	localparam int KEY_W      = 8;
	localparam int LEVEL_W    = 4;
	localparam int IN_TDATA_W = 56;
	localparam int OUT_TDATA_W = 16;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 14;

	// Fault kind codes
	typedef enum logic [1:0] {
		KIND_SHORT    = 2'd0,
		KIND_OPEN     = 2'd1,
		KIND_MISMATCH = 2'd2
	} fault_kind_t;

	// Configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_LED_TYPE     = 3'd0,
		REG_INPUT_OVP    = 3'd1,
		REG_SHORT_OUTPUT = 3'd2,
		REG_SHORT_FB     = 3'd3,
		REG_OPEN_FB      = 3'd4,
		REG_OPEN_OUTPUT  = 3'd5,
		REG_EXPECT_6V    = 3'd6,
		REG_KEY_RELEASE  = 3'd7
	} cfg_reg_t;

	// Reset values of the thresholds
	localparam logic [MV_W-1:0]  RST_LED_TYPE     = 14'd4500;
	localparam logic [MV_W-1:0]  RST_INPUT_OVP    = 14'd4400;
	localparam logic [MV_W-1:0]  RST_SHORT_OUTPUT = 14'd2100;
	localparam logic [MV_W-1:0]  RST_SHORT_FB     = 14'd4800;
	localparam logic [MV_W-1:0]  RST_OPEN_FB      = 14'd250;
	localparam logic [MV_W-1:0]  RST_OPEN_OUTPUT  = 14'd7500;
	localparam logic             RST_EXPECT_6V    = 1'b0;
	localparam logic [KEY_W-1:0] RST_KEY_RELEASE  = 8'd8;

	// One input word, unpacked
	typedef struct packed {
		logic [MV_W-1:0]  feedback_mv;
		logic [MV_W-1:0]  output_mv;
		logic [MV_W-1:0]  battery_mv;
		logic [KEY_W-1:0] key_timer;
		logic             current_present;
		logic             in_fault_mode;
		logic             light_off;
	} in_item_t;

	// Configuration register file
	typedef struct packed {
		logic [MV_W-1:0]  led_type_mv;
		logic [MV_W-1:0]  input_ovp_mv;
		logic [MV_W-1:0]  short_output_mv;
		logic [MV_W-1:0]  short_feedback_mv;
		logic [MV_W-1:0]  open_feedback_mv;
		logic [MV_W-1:0]  open_output_mv;
		logic             expect_six_volt_led;
		logic [KEY_W-1:0] key_release_time;
	} cfg_t;

	// Per-tick classification flags
	typedef struct packed {
		logic guard_ok;
		logic current;
		logic ovp;
		logic is_short;
		logic is_open;
		logic is_mismatch;
	} class_t;

endpackage

`default_nettype wire

### rtl/ofq_classify.sv
// Threshold comparators: classifies one tick as short, open, mismatch or healthy.
// Depends on ofq_pkg.
`default_nettype none

module ofq_classify (
	input  ofq_pkg::in_item_t item,
	input  ofq_pkg::cfg_t     cfg,
	output ofq_pkg::class_t   cls
);
	import ofq_pkg::*;

	logic is_6v;
	logic short_hit;
	logic open_hit;

	// Key guard passes when the light is on and the timer is strictly past the release time
	assign cls.guard_ok = !item.light_off && (item.key_timer > cfg.key_release_time);
	assign cls.current  = item.current_present;
	assign cls.ovp      = item.battery_mv > cfg.input_ovp_mv;

	// Priority: short, then open, then LED type mismatch
	assign is_6v     = item.output_mv > cfg.led_type_mv;
	assign short_hit = (item.output_mv < cfg.short_output_mv) ||
	                   (item.feedback_mv > cfg.short_feedback_mv);
	assign open_hit  = (item.feedback_mv < cfg.open_feedback_mv) ||
	                   (item.output_mv > cfg.open_output_mv);

	assign cls.is_short    = short_hit;
	assign cls.is_open     = !short_hit && open_hit;
	assign cls.is_mismatch = !short_hit && !open_hit && (cfg.expect_six_volt_led != is_6v);

endmodule

`default_nettype wire

### rtl/output_fault_qualifier.sv
// Output fault qualifier: one result word for every input word.
//
// Channels: s_* carries one sampled tick (flags, key timer, three voltages),
// m_* returns the qualified result (overvoltage, output fault, latched kind,
// fault-mode request, counter level). cfg_* writes one threshold register per
// cycle; the user must write only while the block is idle, and the block
// does not enforce it. Writes take effect on the next word. A word passes the
// input register, the comparators and leaky counter, then the output register.
// Throughput: one word per cycle while m_tready is high or the output is empty.
// The fault counter and latched kind update as a word moves into the output
// register, so consecutive words see each other's effect with no bubble.
// Stall: when m_tready is low and m_tvalid high, the output register holds, the input
// register fills, and s_tready drops until the output word is taken.
// Reset (arst_n low): both stages empty, counter 0, kind short, thresholds
// back to their default values.
// Depends on ofq_pkg, ofq_classify and output_fault_qualifier_defines.svh.
`default_nettype none
`include "output_fault_qualifier_defines.svh"

module output_fault_qualifier #(
	parameter int unsigned COUNT_LIMIT = 8
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	// s_tdata: light_off, in_fault_mode, current_present, key_timer[8],
	//          battery_mv[14], output_mv[14], feedback_mv[14], zero pad
	input  wire logic                             s_tvalid,
	output logic                                  s_tready,
	input  wire logic [ofq_pkg::IN_TDATA_W-1:0]   s_tdata,
	// m_tdata: overvoltage_fault, output_fault, output_fault_kind[2],
	//          request_fault_mode, counter_level[4], zero pad
	output logic                                  m_tvalid,
	input  wire logic                             m_tready,
	output logic [ofq_pkg::OUT_TDATA_W-1:0]       m_tdata,
	input  wire logic                             cfg_we,
	input  wire logic [ofq_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  wire logic [ofq_pkg::CFG_DATA_W-1:0]   cfg_wdata
);
	import ofq_pkg::*;

	localparam logic [LEVEL_W-1:0] LIMIT    = LEVEL_W'(COUNT_LIMIT);
	localparam logic [LEVEL_W-1:0] LIMIT_P1 = LEVEL_W'(COUNT_LIMIT + 1);

	cfg_t              cfg_q;
	in_item_t          item_s1;
	logic              valid_s1;
	logic              valid_s2;
	logic              adv_s1;
	logic              adv_s2;
	class_t            cls;
	logic [LEVEL_W-1:0] counter_q;
	fault_kind_t       kind_q;
	logic [LEVEL_W-1:0] counter_nxt;
	fault_kind_t       kind_nxt;
	logic              ovp_nxt;
	logic              ofault_nxt;
	logic              ovp_s2;
	logic              ofault_s2;
	fault_kind_t       kind_s2;
	logic              req_s2;
	logic [LEVEL_W-1:0] level_s2;

	// Configuration register file
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.led_type_mv         <= RST_LED_TYPE;
			cfg_q.input_ovp_mv        <= RST_INPUT_OVP;
			cfg_q.short_output_mv     <= RST_SHORT_OUTPUT;
			cfg_q.short_feedback_mv   <= RST_SHORT_FB;
			cfg_q.open_feedback_mv    <= RST_OPEN_FB;
			cfg_q.open_output_mv      <= RST_OPEN_OUTPUT;
			cfg_q.expect_six_volt_led <= RST_EXPECT_6V;
			cfg_q.key_release_time    <= RST_KEY_RELEASE;
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_LED_TYPE:     cfg_q.led_type_mv         <= cfg_wdata;
				REG_INPUT_OVP:    cfg_q.input_ovp_mv        <= cfg_wdata;
				REG_SHORT_OUTPUT: cfg_q.short_output_mv     <= cfg_wdata;
				REG_SHORT_FB:     cfg_q.short_feedback_mv   <= cfg_wdata;
				REG_OPEN_FB:      cfg_q.open_feedback_mv    <= cfg_wdata;
				REG_OPEN_OUTPUT:  cfg_q.open_output_mv      <= cfg_wdata;
				REG_EXPECT_6V:    cfg_q.expect_six_volt_led <= cfg_wdata[0];
				REG_KEY_RELEASE:  cfg_q.key_release_time    <= cfg_wdata[KEY_W-1:0];
				default:          ;
			endcase
		end
	end

	// Pipeline flow control
	assign adv_s2   = !valid_s2 || m_tready;
	assign adv_s1   = valid_s1 && adv_s2;
	assign s_tready = !valid_s1 || adv_s2;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			item_s1 <= in_item_t'(s_tdata[$bits(in_item_t)-1:0]);
		end
	end

	ofq_classify u_classify (
		.item (item_s1),
		.cfg  (cfg_q),
		.cls  (cls)
	);

	// Leaky counter and kind latch
	always_comb begin
		counter_nxt = counter_q;
		kind_nxt    = kind_q;
		if (!cls.guard_ok) begin
			counter_nxt = '0;
		end else if (cls.current) begin
			if (cls.is_short) begin
				counter_nxt = (counter_q < LIMIT) ? counter_q + LEVEL_W'(2) : LIMIT;
				kind_nxt    = KIND_SHORT;
			end else if (cls.is_open) begin
				counter_nxt = (counter_q < LIMIT) ? counter_q + LEVEL_W'(1) : LIMIT;
				kind_nxt    = KIND_OPEN;
			end else if (cls.is_mismatch) begin
				counter_nxt = (counter_q < LIMIT) ? counter_q + LEVEL_W'(1) : LIMIT;
				kind_nxt    = KIND_MISMATCH;
			end else if (counter_q != '0) begin
				counter_nxt = counter_q - LEVEL_W'(1);
			end
		end
	end

	assign ovp_nxt    = cls.guard_ok && cls.current && cls.ovp;
	assign ofault_nxt = cls.guard_ok && cls.current && (counter_nxt >= LIMIT);

	// Advance state as each word moves to the output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			counter_q <= '0;
			kind_q    <= KIND_SHORT;
		end else if (adv_s1) begin
			counter_q <= counter_nxt;
			kind_q    <= kind_nxt;
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv_s2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			ovp_s2    <= ovp_nxt;
			ofault_s2 <= ofault_nxt;
			kind_s2   <= kind_nxt;
			req_s2    <= (ovp_nxt || ofault_nxt) && !item_s1.in_fault_mode;
			level_s2  <= counter_nxt;
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tdata  = {7'b0, level_s2, req_s2, kind_s2, ofault_s2, ovp_s2};

	// Checks on counter and result consistency
	`OFQ_ASSERT_IMPL(a_counter_bound, 1'b1, counter_q <= LIMIT_P1)
	`OFQ_ASSERT_IMPL(a_fault_needs_limit, m_tvalid && ofault_s2, level_s2 >= LIMIT)
	`OFQ_ASSERT_IMPL(a_req_needs_fault, m_tvalid && req_s2, ovp_s2 || ofault_s2)
	`OFQ_ASSERT_NEXT(a_state_follows, adv_s1, counter_q == level_s2 && kind_q == kind_s2)

endmodule

`default_nettype wire
